### design/sensor_consensus_select_top_macros.svh
// Assertion macros shared by the checker of the sensor consensus selector.
`ifndef SENSOR_CONSENSUS_SELECT_TOP_MACROS_SVH
`define SENSOR_CONSENSUS_SELECT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/scs_pkg.sv
// Types, constants and lookup tables of the sensor consensus selector.
package scs_pkg;

    localparam int PRESS_W          = 21;
    localparam int SENSOR_MAX       = 4;
    localparam int SENSOR_COUNT_DEF = 4;
    localparam int PAIR_COUNT       = 6;
    localparam int MASK_COUNT       = 16;
    localparam int TRIPLE_COUNT     = 4;
    localparam int PIPE_DEPTH       = 4;

    typedef logic [PRESS_W-1:0] press_t;
    typedef logic [3:0]         mask_t;
    typedef logic [2:0]         count_t;

    typedef struct packed {
        press_t pressure_0;
        press_t pressure_1;
        press_t pressure_2;
        press_t pressure_3;
    } sample_t;

    typedef struct packed {
        mask_t  enabled_mask;
        count_t agreeing_count;
    } result_t;

    localparam count_t ONES_IN [MASK_COUNT] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
        3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
    };

    localparam logic [1:0] PAIR_A [PAIR_COUNT] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_B [PAIR_COUNT] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

    localparam mask_t PAIR_MASKS [PAIR_COUNT] = '{
        4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12
    };
    localparam mask_t TRIPLE_MASKS [TRIPLE_COUNT] = '{4'd7, 4'd11, 4'd13, 4'd14};
    localparam mask_t FULL_MASK = 4'd15;

    localparam count_t SIZE_NONE   = 3'd0;
    localparam count_t SIZE_PAIR   = 3'd2;
    localparam count_t SIZE_TRIPLE = 3'd3;
    localparam count_t SIZE_FULL   = 3'd4;

endpackage

### design/sensor_consensus_select_top.sv
// Top level of the sensor consensus selector: a four-stage subset agreement pipeline.
//
//  channel    | handshake              | payload
//  -----------+------------------------+------------------------------------
//  sample     | start, busy            | sample_t: pressure_0 .. pressure_3
//  result     | done                   | result_t: enabled_mask, agreeing_count
//  max_dev    | max_dev_we             | max_dev_wdata (21 bits)
//
//  One beat enters per cycle; its result appears on done after the last stage.
//  Stages: pairwise differences, subset spreads and limit check, best subset
//  per size, final choice by size. busy is always low.
//  Reset clears the valid bits and sets max_deviation to zero.
//  The receiver cannot stall, so nothing inside ever holds.
module sensor_consensus_select_top
    import scs_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sample_t             sample,
    output logic                done,
    output result_t             result,
    input  logic                max_dev_we,
    input  logic [PRESS_W-1:0]  max_dev_wdata
);

    localparam int    SENSOR_USED = (SENSOR_COUNT > SENSOR_MAX) ? SENSOR_MAX : SENSOR_COUNT;
    localparam mask_t SENSOR_SET  = 4'((1 << SENSOR_USED) - 1);

    press_t  max_dev_reg;

    logic    s1_valid_reg;
    press_t  s1_diff_reg [PAIR_COUNT];
    press_t  s1_diff_next [PAIR_COUNT];

    logic    s2_valid_reg;
    press_t  s2_spread_reg [MASK_COUNT];
    logic    s2_surv_reg [MASK_COUNT];
    press_t  s2_spread_next [MASK_COUNT];
    logic    s2_surv_next [MASK_COUNT];

    logic    s3_valid_reg;
    logic    s3_full_reg;
    logic    s3_tri_valid_reg;
    mask_t   s3_tri_mask_reg;
    logic    s3_pair_valid_reg;
    mask_t   s3_pair_mask_reg;
    logic    s3_tri_valid_next;
    mask_t   s3_tri_mask_next;
    logic    s3_pair_valid_next;
    mask_t   s3_pair_mask_next;

    logic    done_reg;
    result_t result_reg;
    result_t result_next;

    press_t  p [SENSOR_MAX];

    assign p[0] = sample.pressure_0;
    assign p[1] = sample.pressure_1;
    assign p[2] = sample.pressure_2;
    assign p[3] = sample.pressure_3;

    always_comb
    begin
        press_t a;
        press_t b;
        for (int k = 0; k < PAIR_COUNT; k++)
        begin
            a = p[PAIR_A[k]];
            b = p[PAIR_B[k]];
            s1_diff_next[k] = (a > b) ? (a - b) : (b - a);
        end
    end

    always_comb
    begin
        mask_t  mv;
        press_t spread;
        for (int m = 0; m < MASK_COUNT; m++)
        begin
            mv     = 4'(m);
            spread = '0;
            for (int k = 0; k < PAIR_COUNT; k++)
            begin
                if (mv[PAIR_A[k]] && mv[PAIR_B[k]] && (s1_diff_reg[k] > spread))
                begin
                    spread = s1_diff_reg[k];
                end
            end
            s2_spread_next[m] = spread;
            s2_surv_next[m]   = (ONES_IN[mv] >= SIZE_PAIR) && ((mv & ~SENSOR_SET) == 4'd0)
                                && (spread <= max_dev_reg);
        end
    end

    always_comb
    begin
        press_t best_tri;
        press_t best_pair;
        mask_t  cand;
        best_tri           = '0;
        best_pair          = '0;
        s3_tri_valid_next  = 1'b0;
        s3_tri_mask_next   = '0;
        s3_pair_valid_next = 1'b0;
        s3_pair_mask_next  = '0;
        for (int c = 0; c < TRIPLE_COUNT; c++)
        begin
            cand = TRIPLE_MASKS[c];
            if (s2_surv_reg[cand] && (!s3_tri_valid_next || (s2_spread_reg[cand] < best_tri)))
            begin
                s3_tri_valid_next = 1'b1;
                s3_tri_mask_next  = cand;
                best_tri          = s2_spread_reg[cand];
            end
        end
        for (int c = 0; c < PAIR_COUNT; c++)
        begin
            cand = PAIR_MASKS[c];
            if (s2_surv_reg[cand] && (!s3_pair_valid_next || (s2_spread_reg[cand] < best_pair)))
            begin
                s3_pair_valid_next = 1'b1;
                s3_pair_mask_next  = cand;
                best_pair          = s2_spread_reg[cand];
            end
        end
    end

    always_comb
    begin
        if (s3_full_reg)
        begin
            result_next.enabled_mask   = FULL_MASK;
            result_next.agreeing_count = SIZE_FULL;
        end
        else if (s3_tri_valid_reg)
        begin
            result_next.enabled_mask   = s3_tri_mask_reg;
            result_next.agreeing_count = SIZE_TRIPLE;
        end
        else if (s3_pair_valid_reg)
        begin
            result_next.enabled_mask   = s3_pair_mask_reg;
            result_next.agreeing_count = SIZE_PAIR;
        end
        else
        begin
            result_next.enabled_mask   = '0;
            result_next.agreeing_count = SIZE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dev_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (max_dev_we)
            begin
                max_dev_reg <= max_dev_wdata;
            end
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_diff_reg       <= s1_diff_next;
        s2_spread_reg     <= s2_spread_next;
        s2_surv_reg       <= s2_surv_next;
        s3_full_reg       <= s2_surv_reg[FULL_MASK];
        s3_tri_valid_reg  <= s3_tri_valid_next;
        s3_tri_mask_reg   <= s3_tri_mask_next;
        s3_pair_valid_reg <= s3_pair_valid_next;
        s3_pair_mask_reg  <= s3_pair_mask_next;
        result_reg        <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### design/scs_checker.sv
// Port-level checker of the sensor consensus selector and its bind to the top level.
`include "sensor_consensus_select_top_macros.svh"

module scs_checker
    import scs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // The reported size always matches the number of sensors in the mask.
    `SCS_ASSERT_NOW(a_count_matches_mask, done,
        $countones(result.enabled_mask) == 32'(result.agreeing_count),
        "agreeing_count does not match enabled_mask")

    // A lone sensor never forms a consensus.
    `SCS_ASSERT_NOW(a_no_single, done, result.agreeing_count != 3'd1,
        "single-sensor subset reported")

    // Every accepted beat produces its result on done.
    `SCS_ASSERT_NOW(a_latency, start && !busy, ##(PIPE_DEPTH) done,
        "result missing after accepted beat")

    // Every result traces back to a beat accepted earlier.
    `SCS_ASSERT_NOW(a_no_spurious, done, $past(start && !busy, PIPE_DEPTH),
        "result without an accepted beat")

endmodule

bind sensor_consensus_select_top scs_checker u_scs_checker (.*);

### bench/consensus_checker.sv
// Checker that predicts each consensus choice and compares it with the block's result beat.
`timescale 1ns / 100ps

module consensus_checker
    import scs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  sample_t             sample,
    input  logic                done,
    input  result_t             result,
    input  logic                max_dev_we,
    input  logic [PRESS_W-1:0]  max_dev_wdata,
    output int                  mismatch_count,
    output int                  pending_results
);

    press_t  spread_limit;
    result_t expected_choices [$];

    function automatic result_t pick_consensus(sample_t s, press_t limit);
        press_t      rd [SENSOR_MAX];
        result_t     best;
        press_t      best_spread;
        press_t      spread;
        press_t      d;
        mask_t       subset;
        int unsigned size;
        rd[0] = s.pressure_0;
        rd[1] = s.pressure_1;
        rd[2] = s.pressure_2;
        rd[3] = s.pressure_3;
        best = '0;
        best_spread = '0;
        for (int m = 1; m < MASK_COUNT; m++) begin
            subset = mask_t'(m);
            size = $countones(subset);
            if (size < 2 || size < best.agreeing_count)
                continue;
            spread = '0;
            for (int i = 0; i < SENSOR_MAX; i++) begin
                for (int j = i + 1; j < SENSOR_MAX; j++) begin
                    if (subset[i] && subset[j]) begin
                        d = (rd[i] > rd[j]) ? rd[i] - rd[j] : rd[j] - rd[i];
                        if (d > spread)
                            spread = d;
                    end
                end
            end
            if (spread > limit)
                continue;
            if (size > best.agreeing_count || spread < best_spread) begin
                best.agreeing_count = count_t'(size);
                best.enabled_mask = subset;
                best_spread = spread;
            end
        end
        return best;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        int      fails;
        if (!rst_n)
        begin
            spread_limit <= '0;
            expected_choices.delete();
            mismatch_count <= 0;
            pending_results <= 0;
        end
        else
        begin
            fails = 0;
            if (done)
            begin
                if (expected_choices.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual mask=%h count=%0d",
                             $time, result.enabled_mask, result.agreeing_count);
                    fails++;
                end
                else
                begin
                    want = expected_choices.pop_front();
                    if (result.enabled_mask !== want.enabled_mask)
                    begin
                        $display("%0t: enabled_mask expected %h actual %h",
                                 $time, want.enabled_mask, result.enabled_mask);
                        fails++;
                    end
                    if (result.agreeing_count !== want.agreeing_count)
                    begin
                        $display("%0t: agreeing_count expected %0d actual %0d",
                                 $time, want.agreeing_count, result.agreeing_count);
                        fails++;
                    end
                end
            end
            if (start && !busy)
                expected_choices.push_back(pick_consensus(sample, spread_limit));
            if (max_dev_we)
                spread_limit <= max_dev_wdata;
            mismatch_count <= mismatch_count + fails;
            pending_results <= expected_choices.size();
        end
    end

endmodule

### bench/tb_sensor_consensus_select_top.sv
// Testbench top that drives sensor sample beats and spread limits and reports the verdict.
`timescale 1ns / 100ps

module tb_sensor_consensus_select_top
    import scs_pkg::*;
();

    localparam int unsigned PRESS_MAX   = (1 << PRESS_W) - 1;
    localparam int          STALL_LIMIT = 2000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_BEATS = 80;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    sample_t            sample;
    logic               done;
    result_t            result;
    logic               max_dev_we;
    logic [PRESS_W-1:0] max_dev_wdata;
    int                 mismatch_count;
    int                 pending_results;
    int                 quiet_cycles;

    int unsigned        limits [PHASES];
    int unsigned        idle_pct;

    sensor_consensus_select_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sample        (sample),
        .done          (done),
        .result        (result),
        .max_dev_we    (max_dev_we),
        .max_dev_wdata (max_dev_wdata)
    );

    consensus_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .sample          (sample),
        .done            (done),
        .result          (result),
        .max_dev_we      (max_dev_we),
        .max_dev_wdata   (max_dev_wdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic sample_t readings(int unsigned a, int unsigned b,
                                         int unsigned c, int unsigned d);
        sample_t s;
        s.pressure_0 = press_t'(a);
        s.pressure_1 = press_t'(b);
        s.pressure_2 = press_t'(c);
        s.pressure_3 = press_t'(d);
        return s;
    endfunction

    // Most readings cluster around a common base so that some subsets agree and others
    // fail by a small margin; a few sensors (all if noise) read anywhere as outliers.
    function automatic sample_t random_sample(int unsigned limit, bit noise);
        int unsigned span;
        int unsigned base;
        int unsigned rd [SENSOR_MAX];
        span = (limit == 0) ? 2 : limit + limit / 2 + 1;
        if (span > PRESS_MAX)
            span = PRESS_MAX;
        base = $urandom_range(PRESS_MAX - span);
        for (int i = 0; i < SENSOR_MAX; i++)
        begin
            if (noise || $urandom_range(5) == 0)
                rd[i] = $urandom & PRESS_MAX;
            else
                rd[i] = base + $urandom_range(span);
        end
        return readings(rd[0], rd[1], rd[2], rd[3]);
    endfunction

    task automatic send_beat(sample_t s);
        start <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_for(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(int unsigned value);
        wait_drained();
        max_dev_we <= 1'b1;
        max_dev_wdata <= press_t'(value);
        @(posedge clk);
        max_dev_we <= 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        sample <= '0;
        max_dev_we <= 1'b0;
        max_dev_wdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_limit(0);
        send_beat(readings(0, 0, 0, 0));
        send_beat(readings(PRESS_MAX, PRESS_MAX, PRESS_MAX, PRESS_MAX));
        send_beat(readings(0, 0, PRESS_MAX, PRESS_MAX));
        send_beat(readings(0, 1, 2, 3));
        send_beat(readings(5, 7, 5, 9));
        send_beat(readings(21'h155555, 21'h0AAAAA, 21'h155555, 21'h0AAAAA));

        set_limit(PRESS_MAX);
        send_beat(readings(0, PRESS_MAX, 5, 7));
        send_beat(readings(PRESS_MAX, 0, 0, PRESS_MAX));

        set_limit(100);
        send_beat(readings(0, 100, 200, 300));
        send_beat(readings(1000, 1050, 1010, 5000));
        send_beat(readings(0, 90, 500, 510));
        send_beat(readings(0, 101, 300, 500));
        send_beat(readings(200, 100, 100, 301));
        send_beat(readings(300, 200, 100, 0));

        limits[0] = 0;
        limits[1] = PRESS_MAX;
        limits[2] = 1;
        limits[3] = 16;
        limits[4] = 1000;
        limits[5] = $urandom_range(PRESS_MAX);
        limits[6] = 65536;
        limits[7] = $urandom_range(255);

        for (int p = 0; p < PHASES; p++)
        begin
            set_limit(limits[p]);
            if (p == PHASES - 1 || $urandom_range(2) == 0)
                idle_pct = 0;
            else
                idle_pct = $urandom_range(10, 40);
            repeat (PHASE_BEATS)
            begin
                if (idle_pct != 0 && $urandom_range(99) < idle_pct)
                    idle_for($urandom_range(1, 18));
                send_beat(random_sample(limits[p], $urandom_range(6) == 0));
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
